FILE: hw/rtl/swa_pkg.sv
// Shared types and constants for the affine-gap local alignment scorer.
`timescale 1ns / 1ps

package swa_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_BASE   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP_OPEN = 2'd2;
    localparam logic [1:0] REG_GAP_EXT  = 2'd3;

    localparam int BEST_W  = 15;
    localparam int COUNT_W = 24;

    localparam logic [BEST_W-1:0]  BEST_MAX  = {BEST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Scoring terms broadcast to every cell
    typedef struct packed {
        logic signed [7:0] match_score;
        logic signed [7:0] mismatch_score;
        logic signed [7:0] gap_extend;
        logic signed [8:0] open_ext;     // gap_open + gap_extend
    } t_cfg;

    // Control part of the word that walks down the cell chain
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [7:0]         base;
        logic [BEST_W-1:0]  best;
        logic [COUNT_W-1:0] count;
    } t_pkt;

    // Query load / clear broadcast
    typedef struct packed {
        logic       load;
        logic       clear;
        logic [7:0] base;
    } t_load;

endpackage

FILE: hw/rtl/swa_cell.sv
// One query row of the alignment array: holds its base and last column scores.
`timescale 1ns / 1ps

module swa_cell #(
    parameter int SW  = 16,
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  swa_pkg::t_cfg        i_cfg,
    input  swa_pkg::t_load       i_load,
    input  logic [IW-1:0]        i_load_idx,
    input  swa_pkg::t_pkt        i_pkt,
    input  logic signed [SW-1:0] i_d_up,
    input  logic signed [SW-1:0] i_p_up,
    input  logic signed [SW-1:0] i_d_diag,
    output swa_pkg::t_pkt        o_pkt,
    output logic signed [SW-1:0] o_d_up,
    output logic signed [SW-1:0] o_p_up,
    output logic signed [SW-1:0] o_d_diag
);
    import swa_pkg::*;

    localparam logic signed [SW-1:0] NEG_INF = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX    = {1'b0, {(SW-1){1'b1}}};

    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1])
            return s[SW] ? NEG_INF : SMAX;
        return s[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [7:0]           r_base;
    logic                 r_used;
    logic signed [SW-1:0] r_score;
    logic signed [SW-1:0] r_hgap;
    t_pkt                 r_pkt;
    logic signed [SW-1:0] r_d_up, r_p_up, r_d_diag;

    logic signed [SW-1:0] w_oe, w_ge, w_w;
    logic signed [SW-1:0] w_p, w_q, w_diag, w_d;
    logic signed [32:0]   w_d_x;
    logic [BEST_W-1:0]    w_c;
    logic                 w_active, w_hit;
    t_pkt                 n_pkt;

    assign w_oe = {{(SW-9){i_cfg.open_ext[8]}}, i_cfg.open_ext};
    assign w_ge = {{(SW-8){i_cfg.gap_extend[7]}}, i_cfg.gap_extend};
    assign w_w  = (r_base == i_pkt.base)
                ? {{(SW-8){i_cfg.match_score[7]}}, i_cfg.match_score}
                : {{(SW-8){i_cfg.mismatch_score[7]}}, i_cfg.mismatch_score};

    assign w_active = i_pkt.valid && r_used;
    assign w_hit    = i_load.load && (i_load_idx == IW'(IDX));

    always_comb begin
        // vertical gap from the row above, horizontal gap from this row's last column
        w_p    = smax(sat_add(i_d_up, w_oe),
                      (i_p_up == NEG_INF) ? NEG_INF : sat_add(i_p_up, w_ge));
        w_q    = smax(sat_add(r_score, w_oe),
                      (r_hgap == NEG_INF) ? NEG_INF : sat_add(r_hgap, w_ge));
        w_diag = sat_add(i_d_diag, w_w);
        w_d    = smax(smax('0, w_diag), smax(w_p, w_q));
        w_d_x  = {{(33-SW){w_d[SW-1]}}, w_d};
        w_c    = (w_d_x > 33'sd32767) ? BEST_MAX : w_d_x[BEST_W-1:0];

        n_pkt = i_pkt;
        if (w_active) begin
            if (w_c > i_pkt.best) begin
                n_pkt.best  = w_c;
                n_pkt.count = COUNT_W'(1);
            end else if (w_c == i_pkt.best && i_pkt.count != COUNT_MAX) begin
                n_pkt.count = i_pkt.count + COUNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_pkt  <= '0;
        end else begin
            if (w_hit)
                r_used <= 1'b1;
            else if (i_load.clear)
                r_used <= 1'b0;
            if (i_en)
                r_pkt <= n_pkt;
        end
    end

    // payload: base, column scores, scores handed down
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_base  <= i_load.base;
            r_score <= '0;
            r_hgap  <= NEG_INF;
        end else if (i_en && w_active) begin
            r_score <= i_pkt.last ? '0 : w_d;
            r_hgap  <= i_pkt.last ? NEG_INF : w_q;
        end
        if (i_en) begin
            r_d_up   <= w_d;
            r_p_up   <= w_p;
            r_d_diag <= r_score;
        end
    end

    assign o_pkt    = r_pkt;
    assign o_d_up   = r_d_up;
    assign o_p_up   = r_p_up;
    assign o_d_diag = r_d_diag;

endmodule

FILE: hw/rtl/smith_waterman_affine_score.sv
// Top level of the affine-gap local alignment scorer: cell chain, merge, output.
`timescale 1ns / 1ps

// Local alignment scorer with affine gaps. Query bases are appended with cmd 0
// (tuser) and dropped with cmd 2; database bases go in with cmd 1, tlast on the
// final base of a sequence. Each database base becomes a word that walks down a
// chain of MAX_QUERY cells, one cell per cycle while the chain is not stalled,
// computing one column of the score matrix; a new database base can be taken
// every cycle while the chain is not stalled, even while earlier ones are still
// in the chain. The final base's result (best score, count) shows up on
// m_axis_tvalid once it has passed the entry register, the cell registers and
// the output register. Appends and clears wait until the chain is empty, which
// takes longer if a waiting result stalls the chain; on an empty chain they are
// accepted without waiting. The whole chain stalls only when a result reaches
// the end while the previous result is still not taken.
// Config writes must happen while the chain is empty.

module smith_waterman_affine_score #(
    parameter int MAX_QUERY   = 256,
    parameter int SCORE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] base
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  logic        s_axis_tlast,   // last_base
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [14:0] best_score, [38:15] best_count, [39] zero
);
    import swa_pkg::*;

    localparam int SW = SCORE_WIDTH;
    localparam int IW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int LW = $clog2(MAX_QUERY + 1);
    localparam int FW = $clog2(MAX_QUERY + 2);

    localparam logic signed [SW-1:0] NEG_INF = {1'b1, {(SW-1){1'b0}}};

    // config registers
    logic signed [7:0] r_match, r_mismatch, r_gap_open, r_gap_ext;
    t_cfg              w_cfg;

    // query length, words in flight, running best
    logic [LW-1:0]      r_len;
    logic [FW-1:0]      r_inflight, n_inflight;
    logic [BEST_W-1:0]  r_run_best;
    logic [COUNT_W-1:0] r_run_count;

    // chain entry and links
    t_pkt                 r_ent, n_ent;
    t_pkt                 w_pkt    [MAX_QUERY+1];
    logic signed [SW-1:0] w_d_up   [MAX_QUERY+1];
    logic signed [SW-1:0] w_p_up   [MAX_QUERY+1];
    logic signed [SW-1:0] w_d_diag [MAX_QUERY+1];

    // output register
    logic               r_out_valid;
    logic [BEST_W-1:0]  r_out_best;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_en, w_acc, w_full;
    t_pkt               w_exit;
    t_load              w_load;
    logic [BEST_W-1:0]  w_mrg_best;
    logic [COUNT_W-1:0] w_mrg_count;
    logic [COUNT_W:0]   w_cnt_sum;

    assign w_cfg.match_score    = r_match;
    assign w_cfg.mismatch_score = r_mismatch;
    assign w_cfg.gap_extend     = r_gap_ext;
    assign w_cfg.open_ext       = $signed({r_gap_open[7], r_gap_open})
                                + $signed({r_gap_ext[7], r_gap_ext});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 8'sd2;
            r_mismatch <= -8'sd1;
            r_gap_open <= -8'sd2;
            r_gap_ext  <= -8'sd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MATCH:    r_match    <= i_cfg_wdata;
                REG_MISMATCH: r_mismatch <= i_cfg_wdata;
                REG_GAP_OPEN: r_gap_open <= i_cfg_wdata;
                REG_GAP_EXT:  r_gap_ext  <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    // chain advances unless a finished result would collide with one still waiting
    assign w_exit = w_pkt[MAX_QUERY];
    assign w_en   = !(w_exit.valid && w_exit.last && r_out_valid && !m_axis_tready);

    // database bases stream freely; append/clear need an empty chain
    assign s_axis_tready = w_en && (s_axis_tuser == CMD_BASE || r_inflight == '0);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_len == LW'(MAX_QUERY));

    assign w_load.load  = w_acc && s_axis_tuser == CMD_APPEND && !w_full;
    assign w_load.clear = w_acc && s_axis_tuser == CMD_CLEAR;
    assign w_load.base  = s_axis_tdata;

    // word entering the chain: empty unless a database base is taken
    always_comb begin
        n_ent = '0;
        if (w_acc && s_axis_tuser == CMD_BASE) begin
            n_ent.valid = 1'b1;
            n_ent.last  = s_axis_tlast;
            n_ent.base  = s_axis_tdata;
        end
    end

    // fold the column's partial best into the running one
    always_comb begin
        w_cnt_sum = {1'b0, r_run_count} + {1'b0, w_exit.count};
        if (w_exit.best > r_run_best) begin
            w_mrg_best  = w_exit.best;
            w_mrg_count = w_exit.count;
        end else if (w_exit.best == r_run_best) begin
            w_mrg_best  = r_run_best;
            w_mrg_count = w_cnt_sum[COUNT_W] ? COUNT_MAX : w_cnt_sum[COUNT_W-1:0];
        end else begin
            w_mrg_best  = r_run_best;
            w_mrg_count = r_run_count;
        end
    end

    always_comb begin
        n_inflight = r_inflight;
        if (w_acc && s_axis_tuser == CMD_BASE)
            n_inflight = n_inflight + FW'(1);
        if (w_en && w_exit.valid)
            n_inflight = n_inflight - FW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_inflight  <= '0;
            r_run_best  <= '0;
            r_run_count <= '0;
            r_ent       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inflight <= n_inflight;
            if (w_load.load)
                r_len <= r_len + LW'(1);
            else if (w_load.clear)
                r_len <= '0;

            if (w_en)
                r_ent <= n_ent;

            if (w_en && w_exit.valid && w_exit.last)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;

            // clear only happens on an empty chain, so no word exits then
            if (w_load.clear) begin
                r_run_best  <= '0;
                r_run_count <= '0;
            end else if (w_en && w_exit.valid) begin
                if (w_exit.last) begin
                    r_run_best  <= '0;
                    r_run_count <= '0;
                end else begin
                    r_run_best  <= w_mrg_best;
                    r_run_count <= w_mrg_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_exit.valid && w_exit.last) begin
            r_out_best  <= w_mrg_best;
            r_out_count <= w_mrg_count;
        end
    end

    // head of chain: boundary row above row 1
    assign w_pkt[0]    = r_ent;
    assign w_d_up[0]   = '0;
    assign w_p_up[0]   = NEG_INF;
    assign w_d_diag[0] = '0;

    for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
        swa_cell #(
            .SW  (SW),
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_cfg      (w_cfg),
            .i_load     (w_load),
            .i_load_idx (r_len[IW-1:0]),
            .i_pkt      (w_pkt[k]),
            .i_d_up     (w_d_up[k]),
            .i_p_up     (w_p_up[k]),
            .i_d_diag   (w_d_diag[k]),
            .o_pkt      (w_pkt[k+1]),
            .o_d_up     (w_d_up[k+1]),
            .o_p_up     (w_p_up[k+1]),
            .o_d_diag   (w_d_diag[k+1])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_best};

    // a word at the chain end must be counted as in flight
    a_exit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_inflight != '0)
        else $error("word at chain end but in-flight count is zero");

    // chain never holds more words than it has stages
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FW'(MAX_QUERY + 1))
        else $error("in-flight count exceeds chain depth");

    // emitting a result restarts the running best
    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_exit.valid && w_exit.last) |=> (r_run_best == '0 && r_run_count == '0))
        else $error("running best not cleared after result");

    // query length stays in range
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_QUERY))
        else $error("query length beyond capacity");

endmodule
